// ----- src/btk_pkg.sv -----
// Shared types and constants for the bounded top-k score table.
// Used by btk_table, the top level and the port checker.
// No dependencies.
`default_nettype none

package btk_pkg;

   // Input field widths
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned SCORE_W = 21;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned VALUE_W = 20;

   // Largest score that passes range validation
   localparam logic [VALUE_W-1:0] SCORE_MAX = 20'd999999;

   // Most result beats a single read command produces, and the index width over them
   localparam int unsigned MAX_READ = 16;
   localparam int unsigned RD_IDX_W = $clog2(MAX_READ);

   // Command codes; codes 5 to 7 are ignored
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 3'd0,
      CMD_RANK   = 3'd1,
      CMD_IS_NEW = 3'd2,
      CMD_READ   = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // Status the table returns for the command held in the input stage
   typedef struct packed {
      logic [COUNT_W-1:0] rank;        // first entry the score equals or beats, 1-based
      logic               is_new;      // score would enter the table
      logic [COUNT_W-1:0] count_next;  // entries held after this command
      logic [COUNT_W-1:0] read_avail;  // min(count, MAX_READ)
      logic [VALUE_W-1:0] entry;       // entry at the read index
   } status_type;

endpackage

`default_nettype wire

// ----- src/btk_table.sv -----
// Sorted score table: a row of entry registers with two compares per entry,
// insertion by a one-place shift, rank and is-new lookups, and a read window.
// Depends on btk_pkg.
`default_nettype none

module btk_table #(
   parameter int ENTRIES = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   commit,
   input  wire  [btk_pkg::CMD_W-1:0]            cmd,
   input  wire                                   score_ok,
   input  wire  [btk_pkg::VALUE_W-1:0]          score_val,
   input  wire  [btk_pkg::RD_IDX_W-1:0]         rd_index,
   output btk_pkg::status_type                   status
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [btk_pkg::VALUE_W-1:0] tab_ff [ENTRIES];
   logic [btk_pkg::VALUE_W-1:0] tab_in [ENTRIES];
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;

   logic [ENTRIES-1:0]          keep;       // entry valid and not beaten by the score
   logic [ENTRIES-1:0]          hit;        // entry valid and score equals or beats it
   logic                        full;
   logic                        insert_ok;
   logic [CNT_W-1:0]            rank_w;
   logic [btk_pkg::VALUE_W-1:0] win [btk_pkg::MAX_READ];
   logic [7:0]                  rank_x;
   logic [7:0]                  count_x;
   logic [7:0]                  avail_x;

   // Per-entry compares
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         keep[i] = (CNT_W'(i) < count_ff) && (tab_ff[i] >= score_val);
         hit[i]  = (CNT_W'(i) < count_ff) && (score_val >= tab_ff[i]);
      end
   end

   // A full table takes the score only if it beats the last entry
   assign full      = (count_ff == CNT_W'(ENTRIES));
   assign insert_ok = score_ok && !(full && keep[ENTRIES-1]);

   // Shift-insert: kept entries stay, the first non-kept cell takes the score,
   // cells after it take their upper neighbor
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (keep[i]) begin
            tab_in[i] = tab_ff[i];
         end else if (i == 0) begin
            tab_in[i] = score_val;
         end else if (keep[(i > 0) ? i - 1 : 0]) begin
            tab_in[i] = score_val;
         end else begin
            tab_in[i] = tab_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   // Rank: first hit from the top
   always_comb begin
      rank_w = '0;
      if (score_ok) begin
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
               rank_w = CNT_W'(i + 1);
            end
         end
      end
   end

   // Entry count after this command
   always_comb begin
      unique case (cmd)
         btk_pkg::CMD_ADD: begin
            count_in = (insert_ok && !full) ? count_ff + CNT_W'(1) : count_ff;
         end
         btk_pkg::CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Read window over the leading entries
   for (genvar j = 0; j < btk_pkg::MAX_READ; j++) begin : g_win
      if (j < ENTRIES) begin : g_used
         assign win[j] = tab_ff[j];
      end else begin : g_pad
         assign win[j] = '0;
      end
   end

   // Status out, masked to the port widths
   always_comb begin
      rank_x              = 8'(rank_w);
      count_x             = 8'(count_in);
      avail_x             = (8'(count_ff) >= 8'(btk_pkg::MAX_READ)) ?
                            8'(btk_pkg::MAX_READ) : 8'(count_ff);
      status.rank         = rank_x[btk_pkg::COUNT_W-1:0];
      status.is_new       = insert_ok;
      status.count_next   = count_x[btk_pkg::COUNT_W-1:0];
      status.read_avail   = avail_x[btk_pkg::COUNT_W-1:0];
      status.entry        = win[rd_index];
   end

   // Entry registers: no reset, cells at or past the count are never read
   always_ff @(posedge clock) begin
      if (commit && (cmd == btk_pkg::CMD_ADD) && insert_ok) begin
         tab_ff <= tab_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (commit) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/bounded_top_k_score_table.sv -----
// Top level of the bounded top-k score table: input stage, read beat counter
// and result register around btk_table.
// Depends on btk_pkg and btk_table.
//
//   channel | dir | tdata (low bit up)                                  | tuser       | tlast
//   req_    | in  | score[20:0], top_count[25:21], zero[31:26]          | command     | -
//   rsp_    | out | score_ok[0], rank[5:1], is_new[6], entry_value[26:7],| entry_valid | last
//           |     | stored_count[31:27]                                 |             |
//
// Each command except read gives one result beat; a read gives
// min(top_count, stored entries, 16) beats, or one beat when that is zero.
// A new item is taken every cycle while the result channel is not stalled; a read
// holds the input stage until its final beat advances. Each item passes the input
// stage and then the result register. Reset is synchronous and empties the table.
// While a result beat is stalled, the held item cannot advance and req_tready stays low.
`default_nettype none

module bounded_top_k_score_table #(
   parameter int ENTRIES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // score[20:0], top_count[25:21], zero pad
   input  wire  [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // score_ok, rank[5:1], is_new, entry_value[26:7],
                                    // stored_count[31:27]
   output logic        rsp_tuser,   // entry_valid
   output logic        rsp_tlast    // last
);

   // Input stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [btk_pkg::CMD_W-1:0]     s1_cmd_ff;
   logic [btk_pkg::SCORE_W-1:0]   s1_score_ff;
   logic [btk_pkg::COUNT_W-1:0]   s1_tc_ff;
   logic [btk_pkg::RD_IDX_W-1:0]  beat_ff, beat_in;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_data_ff;
   logic                         rsp_user_ff;
   logic                         rsp_last_ff;

   logic                         accept;
   logic                         advance;
   logic                         final_beat;
   logic                         score_ok;
   logic                         is_read;
   logic                         has_entry;
   logic [btk_pkg::COUNT_W-1:0]  read_n;
   logic [btk_pkg::COUNT_W-1:0]  rank_o;
   logic                         is_new_o;
   logic [btk_pkg::VALUE_W-1:0]  value_o;
   btk_pkg::status_type          status;

   btk_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .commit    (advance),
      .cmd       (s1_cmd_ff),
      .score_ok  (score_ok),
      .score_val (s1_score_ff[btk_pkg::VALUE_W-1:0]),
      .rd_index  (beat_ff),
      .status    (status)
   );

   // Range check on the held score
   assign score_ok = !s1_score_ff[btk_pkg::SCORE_W-1] &&
                     (s1_score_ff[btk_pkg::VALUE_W-1:0] <= btk_pkg::SCORE_MAX);

   // Read length and beat control
   assign is_read    = (s1_cmd_ff == btk_pkg::CMD_READ);
   assign read_n     = (s1_tc_ff < status.read_avail) ? s1_tc_ff : status.read_avail;
   assign has_entry  = is_read && (read_n != '0);
   assign final_beat = !has_entry ||
                       ((btk_pkg::COUNT_W'(beat_ff) + btk_pkg::COUNT_W'(1)) == read_n);

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || (advance && final_beat);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      beat_in     = beat_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         beat_in     = '0;
      end else if (advance && final_beat) begin
         s1_valid_in = 1'b0;
         beat_in     = '0;
      end else if (advance) begin
         beat_in     = beat_ff + btk_pkg::RD_IDX_W'(1);
      end
   end

   // Result fields
   always_comb begin
      rank_o   = (s1_cmd_ff == btk_pkg::CMD_RANK)   ? status.rank   : '0;
      is_new_o = (s1_cmd_ff == btk_pkg::CMD_IS_NEW) ? status.is_new : 1'b0;
      value_o  = has_entry ? status.entry : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff   <= req_tuser;
         s1_score_ff <= req_tdata[20:0];
         s1_tc_ff    <= req_tdata[25:21];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {status.count_next, value_o, is_new_o, rank_o, score_ok};
         rsp_user_ff <= has_entry;
         rsp_last_ff <= final_beat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- src/btk_checker.sv -----
// Port-level checks on the result channel of the score table, bound to the
// top level. Depends on btk_pkg.
`default_nettype none

module btk_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tuser,
   input wire        rsp_tlast
);

   // A stalled beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Nothing comes out in the cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A beat without an entry is a single-beat result with a zero value
   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[26:7] == '0))
      else $error("beat without entry is not a lone zero beat");

   // An entry beat carries no query answers and an in-range score
   a_entry_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[5:1] == '0) && !rsp_tdata[6] &&
         (rsp_tdata[26:7] <= btk_pkg::SCORE_MAX))
      else $error("entry beat carries a bad field");

endmodule

bind bounded_top_k_score_table btk_checker u_btk_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
